FILE: design/sats_pkg.sv
// ----------------------------------------------------------------------------
// sats_pkg: shared types and constants
// Operation codes, field widths and controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none
package sats_pkg;
	localparam int ADDR_W  = 32;
	localparam int LINE_W  = 26;
	localparam int STAMP_W = 32;
	localparam int OFFS_W  = 6;

	// cache geometry: set index is the low line-number bits
	localparam int NUM_SETS = 64;
	localparam int NUM_WAYS = 8;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;
	localparam logic [1:0] OP_FLUSH  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic capture;  // load input item, start set read
		logic resolve;  // set data valid: compute and write back
		logic take_out; // output register consumed
	} sats_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
	} sats_sts_t;
endpackage
`default_nettype wire

FILE: design/set_assoc_tag_store_fifo_dirty_aware_core.sv
// Each item is captured with its set row read into registers, then resolved into the
// output register with write-back; a new item is accepted only once the last resolves.
// The output register lets the next item be read while a result waits.
// Reset clears valid and dirty flops and both stamp clocks at once; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_tag_store_fifo_dirty_aware_core: set-associative tag store
// FIFO replacement preferring clean lines, with lookup, fill, modify, flush.
// ----------------------------------------------------------------------------
module set_assoc_tag_store_fifo_dirty_aware_core
	import sats_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [ADDR_W-1:0] address,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   hit,
	output logic [5:0]             set_index,
	output logic [2:0]             way_index,
	output logic [LINE_W-1:0]      line_address,
	output logic [STAMP_W-1:0]     fill_time,
	output logic                   dirty,
	output logic                   modify_miss
);
	sats_cmd_t cmd;
	sats_sts_t sts;

	sats_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_stall, .out_valid, .cmd, .sts
	);

	sats_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .operation, .address, .hit, .set_index,
		.way_index, .line_address, .fill_time, .dirty, .modify_miss
	);

`ifndef SYNTHESIS
	// a capture is never followed directly by another capture
	a_no_back_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !cmd.capture) else $error("capture twice in a row");
	// a held result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !cmd.resolve) else $error("result overwritten");
	// miss flag only with no hit
	a_mmiss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(modify_miss && hit)) else $error("modify miss on hit");
`endif
endmodule
`default_nettype wire

FILE: design/sats_datapath.sv
// ----------------------------------------------------------------------------
// sats_datapath: tag store arrays, way compare, victim select, output register
// Reads one set per item, resolves hit and victim; fill/modify write one way.
// ----------------------------------------------------------------------------
`default_nettype none
module sats_datapath
	import sats_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sats_cmd_t            cmd,
	output sats_sts_t                 sts,
	input  wire logic [1:0]           operation,
	input  wire logic [ADDR_W-1:0]    address,
	output logic                      hit,
	output logic [5:0]                set_index,
	output logic [2:0]                way_index,
	output logic [LINE_W-1:0]         line_address,
	output logic [STAMP_W-1:0]        fill_time,
	output logic                      dirty,
	output logic                      modify_miss
);
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ENT   = NUM_SETS * NUM_WAYS;

	// per-line valid and dirty in flops (flush clears at once)
	logic [ENT-1:0] valid_q, dirty_q;
	// tag and stamp memories, one row per set holding all ways
	logic [NUM_WAYS*LINE_W-1:0]  tag_mem   [NUM_SETS];
	logic [NUM_WAYS*STAMP_W-1:0] fill_mem  [NUM_SETS];
	logic [NUM_WAYS*STAMP_W-1:0] mod_mem   [NUM_SETS];
	logic [NUM_WAYS*LINE_W-1:0]  tag_rd_q;
	logic [NUM_WAYS*STAMP_W-1:0] fill_rd_q, mod_rd_q;

	logic [1:0]         op_q;
	logic [LINE_W-1:0]  line_q;
	logic [SET_W-1:0]   set_q;
	logic [STAMP_W-1:0] fill_clk_q, mod_clk_q;

	logic [LINE_W-1:0] line_in;
	logic [SET_W-1:0]  set_in;
	assign line_in = address[ADDR_W-1:OFFS_W];
	assign set_in  = (NUM_SETS > 1) ? line_in[SET_W-1:0] : '0;

	// capture item and read the set row
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			line_q    <= line_in;
			set_q     <= set_in;
			tag_rd_q  <= tag_mem[set_in];
			fill_rd_q <= fill_mem[set_in];
			mod_rd_q  <= mod_mem[set_in];
		end
	end

	// hit search and victim select over the set
	logic [NUM_WAYS-1:0] vrow, drow;
	logic                hit_c, empty_f, clean_f;
	logic [WAY_W-1:0]    hit_w, empty_w, clean_w, dirt_w, vic_w;
	logic [STAMP_W-1:0]  clean_t, dirt_t, fs, ms;
	always_comb begin
		hit_c = 1'b0; hit_w = '0; empty_f = 1'b0; empty_w = '0;
		clean_f = 1'b0; clean_w = '0; clean_t = '0; dirt_w = '0; dirt_t = '0;
		fs = '0; ms = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			vrow[w] = valid_q[{set_q, WAY_W'(w)}];
			drow[w] = dirty_q[{set_q, WAY_W'(w)}];
		end
		for (int w = NUM_WAYS-1; w >= 0; w--) begin
			if (vrow[w] && tag_rd_q[w*LINE_W +: LINE_W] == line_q) begin
				hit_c = 1'b1; hit_w = WAY_W'(w);
			end
			if (!vrow[w]) begin
				empty_f = 1'b1; empty_w = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			fs = fill_rd_q[w*STAMP_W +: STAMP_W];
			ms = mod_rd_q[w*STAMP_W +: STAMP_W];
			if (!drow[w] && (!clean_f || fs < clean_t)) begin
				clean_f = 1'b1; clean_w = WAY_W'(w); clean_t = fs;
			end
			if (w == 0 || ms < dirt_t) begin
				dirt_w = WAY_W'(w); dirt_t = ms;
			end
		end
		vic_w = empty_f ? empty_w : (clean_f ? clean_w : dirt_w);
	end

	logic [STAMP_W-1:0] fill_nx, mod_nx;
	assign fill_nx = (&fill_clk_q) ? fill_clk_q : fill_clk_q + 1'b1;
	assign mod_nx  = (&mod_clk_q) ? mod_clk_q : mod_clk_q + 1'b1;

	logic do_fill, do_mod, do_flush;
	assign do_fill  = cmd.resolve && op_q == OP_ALLOC && !hit_c;
	assign do_mod   = cmd.resolve && op_q == OP_MODIFY && hit_c;
	assign do_flush = cmd.resolve && op_q == OP_FLUSH;

	// memory write-back of the touched way
	always_ff @(posedge clk) begin
		if (do_fill) begin
			tag_mem[set_q][vic_w*LINE_W +: LINE_W]    <= line_q;
			fill_mem[set_q][vic_w*STAMP_W +: STAMP_W] <= fill_nx;
		end
		if (do_mod)
			mod_mem[set_q][hit_w*STAMP_W +: STAMP_W] <= mod_nx;
	end

	// valid, dirty, clocks and output register
	logic out_full_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; dirty_q <= '0;
			fill_clk_q <= '0; mod_clk_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (do_flush) begin
				valid_q <= '0; dirty_q <= '0;
			end
			if (do_fill) begin
				valid_q[{set_q, vic_w}] <= 1'b1;
				dirty_q[{set_q, vic_w}] <= 1'b0;
				fill_clk_q <= fill_nx;
			end
			if (do_mod) begin
				dirty_q[{set_q, hit_w}] <= 1'b1;
				mod_clk_q <= mod_nx;
			end
			if (cmd.resolve)
				out_full_q <= 1'b1;
			else if (cmd.take_out)
				out_full_q <= 1'b0;
		end
	end
	assign sts.out_full = out_full_q;

	logic [WAY_W-1:0] rep_w;
	logic             present;
	assign present = (op_q == OP_ALLOC) || (hit_c && op_q != OP_FLUSH);
	assign rep_w   = hit_c ? hit_w : vic_w;
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			hit          <= hit_c;
			set_index    <= 6'(line_q);
			line_address <= line_q;
			modify_miss  <= op_q == OP_MODIFY && !hit_c;
			way_index    <= present ? 3'(rep_w) : 3'd0;
			fill_time    <= !present ? '0 : (hit_c ?
				fill_rd_q[hit_w*STAMP_W +: STAMP_W] : fill_nx);
			dirty        <= present && hit_c && (drow[hit_w] || op_q == OP_MODIFY);
		end
	end
endmodule
`default_nettype wire

FILE: design/sats_ctrl.sv
// ----------------------------------------------------------------------------
// sats_ctrl: item sequencer
// Accepts an item and reads its set, then resolves once the output slot frees.
// ----------------------------------------------------------------------------
`default_nettype none
module sats_ctrl
	import sats_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire logic      out_stall,
	output logic           out_valid,
	output sats_cmd_t      cmd,
	input  wire sats_sts_t sts
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;
	logic state_q;

	// room for one result: new item resolves after the output slot frees
	logic slot_free;
	assign out_valid    = sts.out_full;
	assign cmd.take_out = sts.out_full && !out_stall;
	assign slot_free    = !sts.out_full || !out_stall;
	assign in_stall     = state_q != ST_IDLE;
	assign cmd.capture  = state_q == ST_IDLE && in_valid;
	assign cmd.resolve  = state_q == ST_READ && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_READ;
				ST_READ: if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
